>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions, clocked on the rising edge and
// disabled while the asynchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define GMI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// Next-cycle implication
`define GMI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

>>> design/gmi_pkg.sv
// ----------------------------------------------------------------------------
// gmi_pkg
// Shared constants and types for the gcd and modular inverse block.
// ----------------------------------------------------------------------------
package gmi_pkg;

	// Default operand width
	localparam int WIDTH_DEF = 32;

	// Width of the status field
	localparam int STATUS_W = 2;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 2'd0,
		ST_NOT_COPRIME = 2'd1,
		ST_ZERO        = 2'd2
	} status_t;

	// Quotient bit stream from the serial divider, MSB first
	typedef struct packed {
		logic valid;
		logic qbit;
		logic last;
	} qstream_t;

endpackage

>>> design/gmi_in_if.sv
// ----------------------------------------------------------------------------
// gmi_in_if
// Operand channel: valid/ready handshake carrying the two operands.
// ----------------------------------------------------------------------------
interface gmi_in_if #(
	parameter int WIDTH = gmi_pkg::WIDTH_DEF
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] operand_a;
	logic [WIDTH-1:0] operand_b;

	modport source (output valid, output operand_a, output operand_b, input ready);
	modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

>>> design/gmi_out_if.sv
// ----------------------------------------------------------------------------
// gmi_out_if
// Result channel: valid/ready handshake carrying gcd, status and inverse.
// ----------------------------------------------------------------------------
interface gmi_out_if #(
	parameter int WIDTH = gmi_pkg::WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic [WIDTH-1:0]              gcd_value;
	logic [gmi_pkg::STATUS_W-1:0]  status;
	logic [WIDTH-1:0]              inverse_value;

	modport source (output valid, output gcd_value, output status, output inverse_value,
		input ready);
	modport sink   (input valid, input gcd_value, input status, input inverse_value,
		output ready);
endinterface

>>> design/gmi_sdiv.sv
// ----------------------------------------------------------------------------
// gmi_sdiv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first,
// remainder available after the last bit.
// ----------------------------------------------------------------------------
module gmi_sdiv #(
	parameter int WIDTH = gmi_pkg::WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WIDTH-1:0]  dividend,
	input  logic [WIDTH-1:0]  divisor,
	output gmi_pkg::qstream_t qs,
	output logic [WIDTH-1:0]  remainder
);
	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] dvd_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             ge;

	// Trial subtract of the divisor from the shifted partial remainder
	always_comb begin
		trial = {rem_q, dvd_q[WIDTH-1]};
		diff  = trial - {1'b0, divisor};
		ge    = !diff[WIDTH];
	end

	// Advance the bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Shift the dividend in and keep the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
			dvd_q <= {dvd_q[WIDTH-2:0], 1'b0};
		end
	end

	always_comb begin
		qs.valid  = busy_q;
		qs.qbit   = ge;
		qs.last   = busy_q && (cnt_q == CW'(1));
		remainder = rem_q;
	end
endmodule

>>> design/gmi_smac.sv
// ----------------------------------------------------------------------------
// gmi_smac
// Serial multiplier: accumulates quotient times coefficient by Horner's rule
// as the quotient bits arrive from the divider.
// ----------------------------------------------------------------------------
module gmi_smac #(
	parameter int WIDTH = gmi_pkg::WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WIDTH-1:0]  mult,
	input  gmi_pkg::qstream_t qs,
	output logic [WIDTH-1:0]  acc
);
	logic [WIDTH-1:0] acc_q;
	logic             run_q;

	// Track an active product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (start) begin
			run_q <= 1'b1;
		end else if (qs.last) begin
			run_q <= 1'b0;
		end
	end

	// Double on each quotient bit and add the coefficient when the bit is set
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
		end else if (run_q && qs.valid) begin
			acc_q <= {acc_q[WIDTH-2:0], 1'b0} + (qs.qbit ? mult : '0);
		end
	end

	assign acc = acc_q;
endmodule

>>> design/gcd_and_modular_inverse_top.sv
// ----------------------------------------------------------------------------
// gcd_and_modular_inverse_top: extended Euclid gcd and modular inverse
// From the accepting edge, a zero smaller operand goes straight to the finish state;
// otherwise each Euclid step runs start, WIDTH quotient bits and update, with at
// most 45 steps at WIDTH=32.
// Throughput: one item at a time; the next operand beat can be taken in the cycle
// after the result is loaded. Reset: asynchronous, active low; clears the sequencer
// and the result valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gcd_and_modular_inverse_top #(
	parameter int WIDTH = gmi_pkg::WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	gmi_in_if.sink    in_ch,
	gmi_out_if.source out_ch
);
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_START  = 5'b00010,
		ST_DIV    = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t              state_q;
	logic [WIDTH-1:0]    m_q;
	logic [WIDTH-1:0]    r0_q;
	logic [WIDTH-1:0]    r1_q;
	logic [WIDTH-1:0]    u0_q;
	logic [WIDTH-1:0]    u1_q;
	logic                neg_q;
	logic                zero_q;
	logic                out_valid_q;
	logic [WIDTH-1:0]    gcd_q;
	gmi_pkg::status_t    status_q;
	logic [WIDTH-1:0]    inv_q;

	logic                in_fire;
	logic                a_ge;
	logic [WIDTH-1:0]    big;
	logic [WIDTH-1:0]    small_op;
	logic                div_start;
	gmi_pkg::qstream_t   qs;
	logic [WIDTH-1:0]    div_rem;
	logic [WIDTH-1:0]    mac_acc;
	logic                out_free;
	logic [WIDTH-1:0]    res_gcd;
	gmi_pkg::status_t    res_status;
	logic [WIDTH-1:0]    inv_raw;
	logic [WIDTH-1:0]    res_inv;

	gmi_sdiv #(.WIDTH(WIDTH)) u_sdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (r0_q),
		.divisor   (r1_q),
		.qs        (qs),
		.remainder (div_rem)
	);

	gmi_smac #(.WIDTH(WIDTH)) u_smac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mult   (u1_q),
		.qs     (qs),
		.acc    (mac_acc)
	);

	// Order the operands: larger is the modulus
	always_comb begin
		a_ge     = in_ch.operand_a >= in_ch.operand_b;
		big      = a_ge ? in_ch.operand_a : in_ch.operand_b;
		small_op = a_ge ? in_ch.operand_b : in_ch.operand_a;
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign div_start   = (state_q == ST_START);
	assign out_free    = !out_valid_q || out_ch.ready;

	// Form the result from the final remainder and coefficient
	always_comb begin
		res_gcd = zero_q ? m_q : r1_q;
		if (zero_q) begin
			res_status = gmi_pkg::ST_ZERO;
		end else if (r1_q != WIDTH'(1)) begin
			res_status = gmi_pkg::ST_NOT_COPRIME;
		end else begin
			res_status = gmi_pkg::ST_OK;
		end
		if (neg_q) begin
			inv_raw = (u1_q <= m_q) ? (m_q - u1_q) : '0;
		end else begin
			inv_raw = u1_q;
		end
		// Reduce modulo m: the only value out of range is m itself
		if (res_status != gmi_pkg::ST_OK || inv_raw == m_q) begin
			res_inv = '0;
		end else begin
			res_inv = inv_raw;
		end
	end

	// Sequence the Euclid steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= (small_op == '0) ? ST_FINISH : ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (qs.last) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= (div_rem == '0) ? ST_FINISH : ST_START;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load operands, then advance remainders and coefficient magnitudes
	always_ff @(posedge clk) begin
		if (in_fire) begin
			m_q    <= big;
			r0_q   <= big;
			r1_q   <= small_op;
			u0_q   <= '0;
			u1_q   <= WIDTH'(1);
			neg_q  <= 1'b0;
			zero_q <= (small_op == '0);
		end else if (state_q == ST_UPDATE && div_rem != '0) begin
			r0_q  <= r1_q;
			r1_q  <= div_rem;
			u0_q  <= u1_q;
			u1_q  <= mac_acc + u0_q;
			neg_q <= !neg_q;
		end
	end

	// Capture the result beat
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			gcd_q    <= res_gcd;
			status_q <= res_status;
			inv_q    <= res_inv;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.gcd_value     = gcd_q;
	assign out_ch.status        = status_q;
	assign out_ch.inverse_value = inv_q;

	// An accepted operand beat either starts a division or finishes at once
	`GMI_ASSERT_NEXT(a_accept_moves, clk, arst_n, in_fire, state_q == ST_START || state_q == ST_FINISH)
	// The divider ends a division only while the sequencer waits for it
	`GMI_ASSERT_SAME(a_last_in_div, clk, arst_n, qs.last, state_q == ST_DIV)
	// Each remainder is below its divisor
	`GMI_ASSERT_SAME(a_rem_below, clk, arst_n, state_q == ST_UPDATE, div_rem < r1_q)
	// An inverse is only reported for a gcd of one
	`GMI_ASSERT_SAME(a_ok_gcd_one, clk, arst_n, out_ch.valid && status_q == gmi_pkg::ST_OK, out_ch.gcd_value == WIDTH'(1))
endmodule
